>>> rtl/wrp_pkg.sv
package wrp_pkg;

    localparam int MAX_RECORDS = 4;

    typedef enum logic [3:0] {
        PH_TYPE,
        PH_LEN_WPA,
        PH_LEN_SKIP,
        PH_SKIP,
        PH_OUI,
        PH_VER_LO,
        PH_VER_HI,
        PH_GROUP,
        PH_PCNT_LO,
        PH_PCNT_HI,
        PH_PSUITE,
        PH_ACNT_LO,
        PH_ACNT_HI,
        PH_ASUITE,
        PH_CAPS,
        PH_IDLE
    } phase_t;

    localparam logic [2:0] KIND_VERSION    = 3'd0;
    localparam logic [2:0] KIND_GROUP      = 3'd1;
    localparam logic [2:0] KIND_PAIR_COUNT = 3'd2;
    localparam logic [2:0] KIND_PAIR_SUITE = 3'd3;
    localparam logic [2:0] KIND_AUTH_COUNT = 3'd4;
    localparam logic [2:0] KIND_AUTH_SUITE = 3'd5;
    localparam logic [2:0] KIND_PREAUTH    = 3'd6;

    localparam logic [7:0] ID_RSN    = 8'h30;
    localparam logic [7:0] ID_VENDOR = 8'hdd;

    localparam logic [15:0] SUITE_TKIP         = 16'd2;
    localparam logic [15:0] CIPHER_MAX_CODED   = 16'd5;
    localparam logic [15:0] SUITE_FOREIGN      = 16'd6;
    localparam logic [15:0] SUITE_OUT_OF_RANGE = 16'd7;
    localparam logic [15:0] AKM_MAX_CODED      = 16'd2;
    localparam logic [15:0] AKM_PROPRIETARY    = 16'd3;
    localparam logic [15:0] AKM_UNKNOWN        = 16'd4;

    typedef struct packed {
        logic        element_type;
        logic [2:0]  record_kind;
        logic [15:0] record_value;
        logic        last_of_element;
    } rec_t;

    typedef struct packed {
        logic [2:0]  count;
        rec_t [3:0]  recs;
    } rec_bundle_t;

    function automatic rec_t make_rec(input logic rsn, input logic [2:0] kind,
                                      input logic [15:0] value, input logic last);
        rec_t r;
        r.element_type    = rsn;
        r.record_kind     = kind;
        r.record_value    = value;
        r.last_of_element = last;
        return r;
    endfunction

    // Vendor element header: OUI 00:50:F2 followed by type 1.
    function automatic logic [7:0] wpa_header_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h00;
            2'd1:    v = 8'h50;
            2'd2:    v = 8'hf2;
            default: v = 8'h01;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] suite_oui_byte(input logic rsn, input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h00;
            2'd1:    v = rsn ? 8'h0f : 8'h50;
            default: v = rsn ? 8'hac : 8'hf2;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] map_cipher(input logic match, input logic [7:0] b);
        logic [15:0] v;
        if (!match)
            v = SUITE_FOREIGN;
        else if ({8'd0, b} > CIPHER_MAX_CODED)
            v = SUITE_OUT_OF_RANGE;
        else
            v = {8'd0, b};
        return v;
    endfunction

    function automatic logic [15:0] map_akm(input logic match, input logic [7:0] b);
        logic [15:0] v;
        if (!match)
            v = AKM_PROPRIETARY;
        else if ({8'd0, b} > AKM_MAX_CODED)
            v = AKM_UNKNOWN;
        else
            v = {8'd0, b};
        return v;
    endfunction

endpackage

>>> rtl/wrp_if.sv
interface wrp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        buffer_start;
    logic [15:0] buffer_length;

    modport source (output valid, output data_byte, output buffer_start,
                    output buffer_length, input ready);
    modport sink (input valid, input data_byte, input buffer_start,
                  input buffer_length, output ready);
endinterface

interface wrp_out_if;
    logic        valid;
    logic        ready;
    logic        element_type;
    logic [2:0]  record_kind;
    logic [15:0] record_value;
    logic        last_of_element;

    modport source (output valid, output element_type, output record_kind,
                    output record_value, output last_of_element, input ready);
    modport sink (input valid, input element_type, input record_kind,
                  input record_value, input last_of_element, output ready);
    modport monitor (input valid, input ready, input element_type, input record_kind,
                     input record_value, input last_of_element);
endinterface

>>> rtl/wrp_parser.sv
module wrp_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 buffer_start,
    input  logic [15:0]          buffer_length,
    output wrp_pkg::rec_bundle_t bundle
);

    logic [15:0]     pos_reg, pos_next, cur_pos;
    logic [15:0]     total_reg, total_next, cur_total;
    logic [8:0]      len_reg, len_next, cur_len;
    logic [8:0]      off_reg, off_next, cur_off;
    wrp_pkg::phase_t phase_reg, phase_next, cur_phase;
    logic            rsn_reg, rsn_next, cur_rsn;
    logic            match_reg, match_next, cur_match;
    logic [15:0]     left_reg, left_next, cur_left;
    logic [7:0]      held_reg, held_next, cur_held;

    logic [16:0]     remaining;
    logic [9:0]      len_raw;
    logic [8:0]      len_clip;
    logic [9:0]      off_plus1;
    logic [15:0]     cnt;
    logic            lt_o1, lt_o2, lt_o4, lt_cnt;
    logic [15:0]     left_dec;
    logic [15:0]     suite_val;
    logic            suite_match;
    logic [1:0]      oui_idx;
    logic [8:0]      off_step;

    always_comb
    begin
        if (buffer_start)
        begin
            cur_pos   = '0;
            cur_total = buffer_length;
            cur_len   = '0;
            cur_off   = '0;
            cur_phase = wrp_pkg::PH_TYPE;
            cur_rsn   = 1'b0;
            cur_match = 1'b1;
            cur_left  = '0;
            cur_held  = '0;
        end
        else
        begin
            cur_pos   = pos_reg;
            cur_total = total_reg;
            cur_len   = len_reg;
            cur_off   = off_reg;
            cur_phase = phase_reg;
            cur_rsn   = rsn_reg;
            cur_match = match_reg;
            cur_left  = left_reg;
            cur_held  = held_reg;
        end
    end

    always_comb
    begin
        remaining = {1'b0, cur_total} - {1'b0, cur_pos} + 17'd1;
        len_raw   = {2'b00, data_byte} + 10'd2;
        len_clip  = ({7'd0, len_raw} > remaining) ? remaining[8:0] : len_raw[8:0];
        off_plus1 = {1'b0, cur_off} + 10'd1;
        off_step  = cur_off + 9'd1;
        cnt       = {data_byte, cur_held};
        lt_o1     = {1'b0, cur_len} < off_plus1 + 10'd1;
        lt_o2     = {1'b0, cur_len} < off_plus1 + 10'd2;
        lt_o4     = {1'b0, cur_len} < off_plus1 + 10'd4;
        lt_cnt    = {10'd0, cur_len} < {9'd0, off_plus1} + {1'b0, cnt, 2'b00};
        left_dec  = cur_left - 16'd1;
        case (cur_phase)
            wrp_pkg::PH_PSUITE: oui_idx = cur_off[1:0] + 2'd2;
            wrp_pkg::PH_OUI:    oui_idx = cur_off[1:0] - 2'd2;
            default:            oui_idx = cur_off[1:0];
        endcase
        suite_match = cur_match & (data_byte == wrp_pkg::suite_oui_byte(cur_rsn, oui_idx));
        suite_val   = (cur_phase == wrp_pkg::PH_ASUITE) ?
                      wrp_pkg::map_akm(cur_match, data_byte) :
                      wrp_pkg::map_cipher(cur_match, data_byte);
    end

    always_comb
    begin
        pos_next    = cur_pos;
        total_next  = cur_total;
        len_next    = cur_len;
        off_next    = cur_off;
        phase_next  = cur_phase;
        rsn_next    = cur_rsn;
        match_next  = cur_match;
        left_next   = cur_left;
        held_next   = cur_held;
        bundle      = '0;

        if (cur_phase != wrp_pkg::PH_IDLE && cur_pos < cur_total)
        begin
            case (cur_phase)
                wrp_pkg::PH_TYPE:
                begin
                    if (remaining < 17'd3)
                    begin
                        phase_next = wrp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        if (data_byte == wrp_pkg::ID_RSN)
                        begin
                            rsn_next   = 1'b1;
                            phase_next = wrp_pkg::PH_LEN_WPA;
                        end
                        else if (data_byte == wrp_pkg::ID_VENDOR)
                        begin
                            rsn_next   = 1'b0;
                            phase_next = wrp_pkg::PH_LEN_WPA;
                        end
                        else
                        begin
                            phase_next = wrp_pkg::PH_LEN_SKIP;
                        end
                        off_next = 9'd1;
                        pos_next = cur_pos + 16'd1;
                    end
                end
                wrp_pkg::PH_LEN_WPA, wrp_pkg::PH_LEN_SKIP:
                begin
                    len_next   = len_clip;
                    off_next   = 9'd2;
                    pos_next   = cur_pos + 16'd1;
                    match_next = 1'b1;
                    if (len_clip <= 9'd2)
                        phase_next = wrp_pkg::PH_TYPE;
                    else if (cur_phase == wrp_pkg::PH_LEN_SKIP)
                        phase_next = wrp_pkg::PH_SKIP;
                    else if (cur_rsn)
                        phase_next = (len_clip < 9'd4) ? wrp_pkg::PH_SKIP : wrp_pkg::PH_VER_LO;
                    else
                        phase_next = (len_clip < 9'd8) ? wrp_pkg::PH_SKIP : wrp_pkg::PH_OUI;
                end
                default:
                begin
                    case (cur_phase)
                        wrp_pkg::PH_OUI:
                        begin
                            match_next = cur_match &
                                         (data_byte == wrp_pkg::wpa_header_byte(oui_idx));
                            if (oui_idx == 2'd3)
                                phase_next = match_next ? wrp_pkg::PH_VER_LO : wrp_pkg::PH_SKIP;
                        end
                        wrp_pkg::PH_VER_LO:
                        begin
                            held_next  = data_byte;
                            phase_next = wrp_pkg::PH_VER_HI;
                        end
                        wrp_pkg::PH_VER_HI:
                        begin
                            bundle.recs[0] = wrp_pkg::make_rec(cur_rsn, wrp_pkg::KIND_VERSION,
                                                               cnt, 1'b0);
                            if (lt_o4)
                            begin
                                bundle.recs[1] = wrp_pkg::make_rec(cur_rsn, wrp_pkg::KIND_GROUP,
                                                                   wrp_pkg::SUITE_TKIP, 1'b0);
                                bundle.recs[2] = wrp_pkg::make_rec(cur_rsn,
                                                                   wrp_pkg::KIND_PAIR_COUNT,
                                                                   16'd1, 1'b0);
                                bundle.recs[3] = wrp_pkg::make_rec(cur_rsn,
                                                                   wrp_pkg::KIND_PAIR_SUITE,
                                                                   wrp_pkg::SUITE_TKIP, 1'b1);
                                bundle.count   = 3'd4;
                                phase_next     = wrp_pkg::PH_SKIP;
                            end
                            else
                            begin
                                bundle.count = 3'd1;
                                match_next   = 1'b1;
                                phase_next   = wrp_pkg::PH_GROUP;
                            end
                        end
                        wrp_pkg::PH_GROUP:
                        begin
                            if (oui_idx != 2'd3)
                            begin
                                match_next = suite_match;
                            end
                            else
                            begin
                                bundle.recs[0] = wrp_pkg::make_rec(cur_rsn, wrp_pkg::KIND_GROUP,
                                                                   suite_val, 1'b0);
                                if (lt_o2)
                                begin
                                    bundle.recs[1] = wrp_pkg::make_rec(cur_rsn,
                                                                       wrp_pkg::KIND_PAIR_COUNT,
                                                                       16'd1, 1'b0);
                                    bundle.recs[2] = wrp_pkg::make_rec(cur_rsn,
                                                                       wrp_pkg::KIND_PAIR_SUITE,
                                                                       wrp_pkg::SUITE_TKIP, 1'b1);
                                    bundle.count   = 3'd3;
                                    phase_next     = wrp_pkg::PH_SKIP;
                                end
                                else
                                begin
                                    bundle.count = 3'd1;
                                    phase_next   = wrp_pkg::PH_PCNT_LO;
                                end
                            end
                        end
                        wrp_pkg::PH_PCNT_LO:
                        begin
                            held_next  = data_byte;
                            phase_next = wrp_pkg::PH_PCNT_HI;
                        end
                        wrp_pkg::PH_ACNT_LO:
                        begin
                            held_next  = data_byte;
                            phase_next = wrp_pkg::PH_ACNT_HI;
                        end
                        wrp_pkg::PH_PCNT_HI:
                        begin
                            bundle.count = 3'd1;
                            if (lt_cnt)
                            begin
                                bundle.recs[0] = wrp_pkg::make_rec(cur_rsn,
                                                                   wrp_pkg::KIND_PAIR_COUNT,
                                                                   16'd0, 1'b1);
                                phase_next     = wrp_pkg::PH_SKIP;
                            end
                            else if (cnt == 16'd0)
                            begin
                                bundle.recs[0] = wrp_pkg::make_rec(cur_rsn,
                                                                   wrp_pkg::KIND_PAIR_COUNT,
                                                                   16'd0, lt_o2);
                                phase_next     = lt_o2 ? wrp_pkg::PH_SKIP : wrp_pkg::PH_ACNT_LO;
                            end
                            else
                            begin
                                bundle.recs[0] = wrp_pkg::make_rec(cur_rsn,
                                                                   wrp_pkg::KIND_PAIR_COUNT,
                                                                   cnt, 1'b0);
                                left_next      = cnt;
                                match_next     = 1'b1;
                                phase_next     = wrp_pkg::PH_PSUITE;
                            end
                        end
                        wrp_pkg::PH_ACNT_HI:
                        begin
                            bundle.count = 3'd1;
                            if (lt_cnt)
                            begin
                                bundle.recs[0] = wrp_pkg::make_rec(cur_rsn,
                                                                   wrp_pkg::KIND_AUTH_COUNT,
                                                                   16'd0, 1'b1);
                                phase_next     = wrp_pkg::PH_SKIP;
                            end
                            else if (cnt == 16'd0)
                            begin
                                bundle.recs[0] = wrp_pkg::make_rec(cur_rsn,
                                                                   wrp_pkg::KIND_AUTH_COUNT,
                                                                   16'd0, lt_o1);
                                phase_next     = lt_o1 ? wrp_pkg::PH_SKIP : wrp_pkg::PH_CAPS;
                            end
                            else
                            begin
                                bundle.recs[0] = wrp_pkg::make_rec(cur_rsn,
                                                                   wrp_pkg::KIND_AUTH_COUNT,
                                                                   cnt, 1'b0);
                                left_next      = cnt;
                                match_next     = 1'b1;
                                phase_next     = wrp_pkg::PH_ASUITE;
                            end
                        end
                        wrp_pkg::PH_PSUITE:
                        begin
                            if (oui_idx != 2'd3)
                            begin
                                match_next = suite_match;
                            end
                            else
                            begin
                                match_next   = 1'b1;
                                left_next    = left_dec;
                                bundle.count = 3'd1;
                                if (left_dec != 16'd0)
                                begin
                                    bundle.recs[0] = wrp_pkg::make_rec(cur_rsn,
                                                                       wrp_pkg::KIND_PAIR_SUITE,
                                                                       suite_val, 1'b0);
                                end
                                else
                                begin
                                    bundle.recs[0] = wrp_pkg::make_rec(cur_rsn,
                                                                       wrp_pkg::KIND_PAIR_SUITE,
                                                                       suite_val, lt_o2);
                                    phase_next = lt_o2 ? wrp_pkg::PH_SKIP : wrp_pkg::PH_ACNT_LO;
                                end
                            end
                        end
                        wrp_pkg::PH_ASUITE:
                        begin
                            if (oui_idx != 2'd3)
                            begin
                                match_next = suite_match;
                            end
                            else
                            begin
                                match_next   = 1'b1;
                                left_next    = left_dec;
                                bundle.count = 3'd1;
                                if (left_dec != 16'd0)
                                begin
                                    bundle.recs[0] = wrp_pkg::make_rec(cur_rsn,
                                                                       wrp_pkg::KIND_AUTH_SUITE,
                                                                       suite_val, 1'b0);
                                end
                                else
                                begin
                                    bundle.recs[0] = wrp_pkg::make_rec(cur_rsn,
                                                                       wrp_pkg::KIND_AUTH_SUITE,
                                                                       suite_val, lt_o1);
                                    phase_next = lt_o1 ? wrp_pkg::PH_SKIP : wrp_pkg::PH_CAPS;
                                end
                            end
                        end
                        wrp_pkg::PH_CAPS:
                        begin
                            bundle.recs[0] = wrp_pkg::make_rec(cur_rsn, wrp_pkg::KIND_PREAUTH,
                                                               {15'd0, data_byte[0]}, 1'b1);
                            bundle.count   = 3'd1;
                            phase_next     = wrp_pkg::PH_SKIP;
                        end
                        default:
                        begin
                        end
                    endcase
                    off_next = off_step;
                    pos_next = cur_pos + 16'd1;
                    if (off_step >= cur_len)
                        phase_next = wrp_pkg::PH_TYPE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            total_reg <= '0;
            len_reg   <= '0;
            off_reg   <= '0;
            phase_reg <= wrp_pkg::PH_TYPE;
            rsn_reg   <= 1'b0;
            match_reg <= 1'b1;
            left_reg  <= '0;
            held_reg  <= '0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            total_reg <= total_next;
            len_reg   <= len_next;
            off_reg   <= off_next;
            phase_reg <= phase_next;
            rsn_reg   <= rsn_next;
            match_reg <= match_next;
            left_reg  <= left_next;
            held_reg  <= held_next;
        end
    end

endmodule

>>> rtl/wrp_rec_fifo.sv
module wrp_rec_fifo #(
    parameter int DEPTH_LOG2 = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  wrp_pkg::rec_bundle_t bundle,
    output logic                 has_room,
    wrp_out_if.source            records
);

    localparam int DEPTH = 1 << DEPTH_LOG2;
    localparam logic [DEPTH_LOG2:0] ROOM_LIMIT = (DEPTH_LOG2 + 1)'(DEPTH - wrp_pkg::MAX_RECORDS);

    wrp_pkg::rec_t               mem [DEPTH];
    logic [DEPTH_LOG2-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [DEPTH_LOG2-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [DEPTH_LOG2:0]         count_reg, count_next;
    logic [2:0]                  n_push;
    logic                        pop;
    wrp_pkg::rec_t               head;

    assign n_push   = push ? bundle.count : 3'd0;
    assign pop      = records.valid && records.ready;
    assign has_room = count_reg <= ROOM_LIMIT;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + DEPTH_LOG2'(n_push);
        rd_ptr_next = rd_ptr_reg + DEPTH_LOG2'(pop);
        count_next  = count_reg + (DEPTH_LOG2 + 1)'(n_push) - (DEPTH_LOG2 + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < wrp_pkg::MAX_RECORDS; i++)
        begin
            if (3'(i) < n_push)
                mem[wr_ptr_reg + DEPTH_LOG2'(i)] <= bundle.recs[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head                    = mem[rd_ptr_reg];
    assign records.valid           = count_reg != '0;
    assign records.element_type    = head.element_type;
    assign records.record_kind     = head.record_kind;
    assign records.record_value    = head.record_value;
    assign records.last_of_element = head.last_of_element;

endmodule

>>> rtl/wpa_rsn_element_parser.sv
// WPA/RSN information element parser.
// The stream channel carries one byte of an information-element buffer per
// request; buffer_start marks the first byte of a buffer and buffer_length
// gives its total size on that byte. The records channel carries the decoded
// records of RSN and WPA elements, one record per request.
// A byte is parsed in the cycle it is accepted, and the up to four records it
// causes are written into a small record queue at the same clock edge and are
// offered in order from its registered head. One byte is taken per cycle as
// long as the queue has room for four more records; the queue depth is
// 2**DEPTH_LOG2 records, and ready drops while more than depth minus four are
// held. Bytes that cause several records therefore cost extra cycles only
// when the receiver drains slower than they arrive.
// Reset empties the queue and returns the walk to its type phase; no buffer is
// open until a byte with buffer_start arrives. When the receiver stalls, the
// head record holds steady and the queue fills until ready drops.
module wpa_rsn_element_parser #(
    parameter int DEPTH_LOG2 = 3
) (
    input  logic      clk,
    input  logic      rst_n,
    wrp_in_if.sink    stream,
    wrp_out_if.source records
);

    wrp_pkg::rec_bundle_t bundle;
    logic                 has_room;
    logic                 accept;

    assign stream.ready = has_room;
    assign accept       = stream.valid && has_room;

    wrp_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (stream.data_byte),
        .buffer_start  (stream.buffer_start),
        .buffer_length (stream.buffer_length),
        .bundle        (bundle)
    );

    wrp_rec_fifo #(
        .DEPTH_LOG2 (DEPTH_LOG2)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .bundle   (bundle),
        .has_room (has_room),
        .records  (records)
    );

endmodule

>>> rtl/wrp_checker.sv
module wrp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    input  logic        ready,
    input  logic [2:0]  record_kind,
    input  logic [15:0] record_value,
    input  logic        last_of_element
);

    // A stalled record must stay offered with the same kind and value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=>
            valid && $stable(record_kind) && $stable(record_value))
        else $error("record changed while stalled");

    // The preauthentication bit always closes its element.
    a_preauth: assert property (@(posedge clk) disable iff (!rst_n)
        valid && record_kind == wrp_pkg::KIND_PREAUTH |->
            last_of_element && record_value <= 16'd1)
        else $error("bad preauthentication record");

    // Cipher suite values never exceed the out-of-range code.
    a_cipher: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (record_kind == wrp_pkg::KIND_GROUP ||
                  record_kind == wrp_pkg::KIND_PAIR_SUITE) |->
            record_value <= wrp_pkg::SUITE_OUT_OF_RANGE)
        else $error("cipher code out of range");

    // Key management suite values never exceed the unknown code.
    a_akm: assert property (@(posedge clk) disable iff (!rst_n)
        valid && record_kind == wrp_pkg::KIND_AUTH_SUITE |->
            record_value <= wrp_pkg::AKM_UNKNOWN)
        else $error("key management code out of range");

endmodule

bind wpa_rsn_element_parser wrp_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .valid           (records.valid),
    .ready           (records.ready),
    .record_kind     (records.record_kind),
    .record_value    (records.record_value),
    .last_of_element (records.last_of_element)
);

>>> sim/wpa_rsn_record_checker.sv
module wpa_rsn_record_checker
    import wrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    wrp_in_if          stream,
    wrp_out_if.monitor records,
    output int         fail_count,
    output int         outstanding,
    output int         records_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] VENDOR_HEADER [4] = '{8'h00, 8'h50, 8'hf2, 8'h01};
    localparam logic [7:0] RSN_OUI [3] = '{8'h00, 8'h0f, 8'hac};
    localparam logic [7:0] WPA_OUI [3] = '{8'h00, 8'h50, 8'hf2};

    logic [15:0] buf_pos;
    logic [15:0] buf_total;
    logic [15:0] suites_left;
    logic [8:0]  elem_len;
    logic [8:0]  elem_off;
    phase_t      walk_phase;
    logic        elem_is_rsn;
    logic        oui_ok;
    logic [7:0]  low_byte;
    rec_t        pending_records[$];

    function automatic void restart_walk();
        buf_pos     = '0;
        buf_total   = '0;
        elem_len    = '0;
        elem_off    = '0;
        walk_phase  = PH_TYPE;
        elem_is_rsn = 1'b0;
        oui_ok      = 1'b1;
        suites_left = '0;
        low_byte    = '0;
    endfunction

    function automatic void emit_record(input logic [2:0] kind, input logic [15:0] value,
                                        input logic last);
        rec_t r;
        r.element_type    = elem_is_rsn;
        r.record_kind     = kind;
        r.record_value    = value;
        r.last_of_element = last;
        pending_records.push_back(r);
    endfunction

    // A short element falls back to a single TKIP pairwise suite.
    function automatic void emit_tkip_pairwise();
        emit_record(KIND_PAIR_COUNT, 16'd1, 1'b0);
        emit_record(KIND_PAIR_SUITE, SUITE_TKIP, 1'b1);
    endfunction

    function automatic void match_oui(input int idx, input logic [7:0] b);
        logic [7:0] want;
        want = elem_is_rsn ? RSN_OUI[idx] : WPA_OUI[idx];
        if (b != want)
            oui_ok = 1'b0;
    endfunction

    function automatic logic [15:0] cipher_code(input logic [7:0] b);
        if (!oui_ok)
            return SUITE_FOREIGN;
        if ({8'd0, b} > CIPHER_MAX_CODED)
            return SUITE_OUT_OF_RANGE;
        return {8'd0, b};
    endfunction

    function automatic logic [15:0] akm_code(input logic [7:0] b);
        if (!oui_ok)
            return AKM_PROPRIETARY;
        if ({8'd0, b} > AKM_MAX_CODED)
            return AKM_UNKNOWN;
        return {8'd0, b};
    endfunction

    function automatic void parse_ie_byte(input logic [7:0] b, input logic start,
                                          input logic [15:0] total);
        int          span;
        int          off;
        int          nxt;
        int          cnt;
        int          room;
        logic [15:0] code;
        if (start)
        begin
            restart_walk();
            buf_total = total;
        end
        if (walk_phase == PH_IDLE || buf_pos >= buf_total)
            return;
        if (walk_phase == PH_TYPE)
        begin
            if (int'(buf_total) - int'(buf_pos) < 2)
            begin
                walk_phase = PH_IDLE;
                return;
            end
            if (b == ID_RSN)
            begin
                elem_is_rsn = 1'b1;
                walk_phase  = PH_LEN_WPA;
            end
            else if (b == ID_VENDOR)
            begin
                elem_is_rsn = 1'b0;
                walk_phase  = PH_LEN_WPA;
            end
            else
                walk_phase = PH_LEN_SKIP;
            elem_off = 9'd1;
            buf_pos  = buf_pos + 16'd1;
            return;
        end
        if (walk_phase == PH_LEN_WPA || walk_phase == PH_LEN_SKIP)
        begin
            room = int'(buf_total) - int'(buf_pos) + 1;
            span = int'(b) + 2;
            if (span > room)
                span = room;
            elem_len = 9'(span);
            elem_off = 9'd2;
            buf_pos  = buf_pos + 16'd1;
            oui_ok   = 1'b1;
            if (span <= 2)
                walk_phase = PH_TYPE;
            else if (walk_phase == PH_LEN_SKIP)
                walk_phase = PH_SKIP;
            else if (elem_is_rsn)
                walk_phase = (span < 4) ? PH_SKIP : PH_VER_LO;
            else
                walk_phase = (span < 8) ? PH_SKIP : PH_OUI;
            return;
        end

        span = int'(elem_len);
        off  = int'(elem_off);
        nxt  = off + 1;
        case (walk_phase)
            PH_OUI:
            begin
                if (b != VENDOR_HEADER[(off - 2) % 4])
                    oui_ok = 1'b0;
                if ((off - 2) % 4 == 3)
                    walk_phase = oui_ok ? PH_VER_LO : PH_SKIP;
            end
            PH_VER_LO:
            begin
                low_byte   = b;
                walk_phase = PH_VER_HI;
            end
            PH_VER_HI:
            begin
                emit_record(KIND_VERSION, {b, low_byte}, 1'b0);
                if (span < nxt + 4)
                begin
                    emit_record(KIND_GROUP, SUITE_TKIP, 1'b0);
                    emit_tkip_pairwise();
                    walk_phase = PH_SKIP;
                end
                else
                begin
                    oui_ok     = 1'b1;
                    walk_phase = PH_GROUP;
                end
            end
            PH_GROUP:
            begin
                if (off % 4 < 3)
                    match_oui(off % 4, b);
                else
                begin
                    emit_record(KIND_GROUP, cipher_code(b), 1'b0);
                    if (span < nxt + 2)
                    begin
                        emit_tkip_pairwise();
                        walk_phase = PH_SKIP;
                    end
                    else
                        walk_phase = PH_PCNT_LO;
                end
            end
            PH_PCNT_LO:
            begin
                low_byte   = b;
                walk_phase = PH_PCNT_HI;
            end
            PH_PCNT_HI:
            begin
                cnt = int'({b, low_byte});
                if (span < nxt + 4 * cnt)
                begin
                    emit_record(KIND_PAIR_COUNT, 16'd0, 1'b1);
                    walk_phase = PH_SKIP;
                end
                else if (cnt == 0)
                begin
                    if (span < nxt + 2)
                    begin
                        emit_record(KIND_PAIR_COUNT, 16'd0, 1'b1);
                        walk_phase = PH_SKIP;
                    end
                    else
                    begin
                        emit_record(KIND_PAIR_COUNT, 16'd0, 1'b0);
                        walk_phase = PH_ACNT_LO;
                    end
                end
                else
                begin
                    emit_record(KIND_PAIR_COUNT, 16'(cnt), 1'b0);
                    suites_left = 16'(cnt);
                    oui_ok      = 1'b1;
                    walk_phase  = PH_PSUITE;
                end
            end
            PH_PSUITE:
            begin
                if ((off + 2) % 4 < 3)
                    match_oui((off + 2) % 4, b);
                else
                begin
                    code        = cipher_code(b);
                    oui_ok      = 1'b1;
                    suites_left = suites_left - 16'd1;
                    if (suites_left != 16'd0)
                        emit_record(KIND_PAIR_SUITE, code, 1'b0);
                    else if (span < nxt + 2)
                    begin
                        emit_record(KIND_PAIR_SUITE, code, 1'b1);
                        walk_phase = PH_SKIP;
                    end
                    else
                    begin
                        emit_record(KIND_PAIR_SUITE, code, 1'b0);
                        walk_phase = PH_ACNT_LO;
                    end
                end
            end
            PH_ACNT_LO:
            begin
                low_byte   = b;
                walk_phase = PH_ACNT_HI;
            end
            PH_ACNT_HI:
            begin
                cnt = int'({b, low_byte});
                if (span < nxt + 4 * cnt)
                begin
                    emit_record(KIND_AUTH_COUNT, 16'd0, 1'b1);
                    walk_phase = PH_SKIP;
                end
                else if (cnt == 0)
                begin
                    if (span < nxt + 1)
                    begin
                        emit_record(KIND_AUTH_COUNT, 16'd0, 1'b1);
                        walk_phase = PH_SKIP;
                    end
                    else
                    begin
                        emit_record(KIND_AUTH_COUNT, 16'd0, 1'b0);
                        walk_phase = PH_CAPS;
                    end
                end
                else
                begin
                    emit_record(KIND_AUTH_COUNT, 16'(cnt), 1'b0);
                    suites_left = 16'(cnt);
                    oui_ok      = 1'b1;
                    walk_phase  = PH_ASUITE;
                end
            end
            PH_ASUITE:
            begin
                if (off % 4 < 3)
                    match_oui(off % 4, b);
                else
                begin
                    code        = akm_code(b);
                    oui_ok      = 1'b1;
                    suites_left = suites_left - 16'd1;
                    if (suites_left != 16'd0)
                        emit_record(KIND_AUTH_SUITE, code, 1'b0);
                    else if (span < nxt + 1)
                    begin
                        emit_record(KIND_AUTH_SUITE, code, 1'b1);
                        walk_phase = PH_SKIP;
                    end
                    else
                    begin
                        emit_record(KIND_AUTH_SUITE, code, 1'b0);
                        walk_phase = PH_CAPS;
                    end
                end
            end
            PH_CAPS:
            begin
                emit_record(KIND_PREAUTH, {15'd0, b[0]}, 1'b1);
                walk_phase = PH_SKIP;
            end
            default:
            begin
            end
        endcase
        elem_off = elem_off + 9'd1;
        buf_pos  = buf_pos + 16'd1;
        if (elem_off >= elem_len)
            walk_phase = PH_TYPE;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rec_t head;
        if (!rst_n)
        begin
            restart_walk();
            pending_records.delete();
            fail_count      = 0;
            outstanding     = 0;
            records_checked = 0;
        end
        else
        begin
            if (records.valid && records.ready)
            begin
                records_checked++;
                if (pending_records.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected record type %0d kind %0d value %0h last %0d",
                                 $realtime, records.element_type, records.record_kind,
                                 records.record_value, records.last_of_element);
                    fail_count++;
                end
                else
                begin
                    head = pending_records.pop_front();
                    if (head.element_type !== records.element_type ||
                        head.record_kind !== records.record_kind ||
                        head.record_value !== records.record_value ||
                        head.last_of_element !== records.last_of_element)
                    begin
                        if (fail_count < 10)
                            $display({"%0t: record mismatch, expected type %0d kind %0d",
                                      " value %0h last %0d, got type %0d kind %0d",
                                      " value %0h last %0d"},
                                     $realtime, head.element_type, head.record_kind,
                                     head.record_value, head.last_of_element,
                                     records.element_type, records.record_kind,
                                     records.record_value, records.last_of_element);
                        fail_count++;
                    end
                end
            end
            if (stream.valid && stream.ready)
                parse_ie_byte(stream.data_byte, stream.buffer_start, stream.buffer_length);
            outstanding = pending_records.size();
        end
    end

endmodule

>>> sim/tb_wpa_rsn_element_parser.sv
module tb_wpa_rsn_element_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import wrp_pkg::*;

    typedef logic [7:0] octet_q_t[$];

    localparam logic [7:0] VENDOR_HEADER [4] = '{8'h00, 8'h50, 8'hf2, 8'h01};
    localparam logic [7:0] RSN_OUI [3] = '{8'h00, 8'h0f, 8'hac};
    localparam logic [7:0] WPA_OUI [3] = '{8'h00, 8'h50, 8'hf2};

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   bytes_sent;
    int   buffers_sent;
    int   fail_count;
    int   outstanding;
    int   records_checked;

    wrp_in_if  stream_bus ();
    wrp_out_if record_bus ();

    wpa_rsn_element_parser u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream_bus),
        .records (record_bus)
    );

    wpa_rsn_record_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .stream          (stream_bus),
        .records         (record_bus),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .records_checked (records_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        record_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            record_bus.ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic void push_word(ref octet_q_t q, input logic [15:0] w);
        q.push_back(w[7:0]);
        q.push_back(w[15:8]);
    endfunction

    function automatic void push_suite(ref octet_q_t q, input logic rsn, input logic akm);
        int pick;
        int i;
        pick = $urandom_range(0, 9);
        for (i = 0; i < 3; i++)
        begin
            if (pick == 0)
                q.push_back(8'($urandom));
            else if (pick == 1)
                q.push_back(rsn ? WPA_OUI[i] : RSN_OUI[i]);
            else
                q.push_back(rsn ? RSN_OUI[i] : WPA_OUI[i]);
        end
        if ($urandom_range(0, 3) == 0)
            q.push_back(8'($urandom));
        else
            q.push_back(8'(akm ? $urandom_range(0, 4) : $urandom_range(0, 7)));
    endfunction

    function automatic void push_ie_body(ref octet_q_t q, input logic rsn);
        int lst;
        int n;
        int k;
        int i;
        push_word(q, ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd1);
        push_suite(q, rsn, 1'b0);
        for (lst = 0; lst < 2; lst++)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
            push_word(q, 16'(n));
            k = (n > 4) ? $urandom_range(0, 2) : n;
            for (i = 0; i < k; i++)
                push_suite(q, rsn, lst == 1);
        end
        push_word(q, 16'($urandom));
        if ($urandom_range(0, 3) == 0)
            for (i = $urandom_range(1, 3); i > 0; i--)
                q.push_back(8'($urandom));
    endfunction

    function automatic void push_element(ref octet_q_t q);
        octet_q_t   body;
        int         pick;
        int         keep;
        int         i;
        logic [7:0] id;
        logic [7:0] span;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            id = ID_RSN;
            push_ie_body(body, 1'b1);
        end
        else if (pick < 75)
        begin
            id = ID_VENDOR;
            for (i = 0; i < 4; i++)
                body.push_back(VENDOR_HEADER[i]);
            if ($urandom_range(0, 9) == 0)
                body[$urandom_range(0, 3)] = 8'($urandom);
            push_ie_body(body, 1'b0);
        end
        else
        begin
            id = 8'($urandom);
            for (i = $urandom_range(0, 6); i > 0; i--)
                body.push_back(8'($urandom));
        end
        if (body.size() > 0 && $urandom_range(0, 3) == 0)
        begin
            keep = $urandom_range(0, body.size() - 1);
            while (body.size() > keep)
                void'(body.pop_back());
        end
        span = 8'(body.size());
        if ($urandom_range(0, 14) == 0)
            span = 8'($urandom);
        q.push_back(id);
        q.push_back(span);
        for (i = 0; i < body.size(); i++)
            q.push_back(body[i]);
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_byte(input logic [7:0] b, input logic start, input logic [15:0] total);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            stream_bus.valid = 1'b0;
            @(negedge clk);
        end
        stream_bus.valid         = 1'b1;
        stream_bus.data_byte     = b;
        stream_bus.buffer_start  = start;
        stream_bus.buffer_length = total;
        @(posedge clk);
        while (!stream_bus.ready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_buffer(input octet_q_t bytes, input logic [15:0] total);
        int i;
        for (i = 0; i < bytes.size(); i++)
            send_byte(bytes[i], i == 0, (i == 0) ? total : 16'($urandom));
        buffers_sent++;
    endtask

    task automatic send_random_buffer();
        octet_q_t    bytes;
        int          i;
        int          pick;
        int          keep;
        logic [15:0] total;
        for (i = $urandom_range(1, 4); i > 0; i--)
            push_element(bytes);
        total = 16'(bytes.size());
        pick  = $urandom_range(0, 99);
        if (pick < 10)
            total = (total > 16'd4) ? total - 16'($urandom_range(1, 4)) : 16'd0;
        else if (pick < 16)
            total = 16'($urandom);
        else if (pick < 22)
        begin
            keep = $urandom_range(1, bytes.size());
            while (bytes.size() > keep)
                void'(bytes.pop_back());
        end
        else if (pick < 25)
            total = 16'($urandom_range(0, 1));
        else if (pick < 32)
            for (i = $urandom_range(1, 3); i > 0; i--)
                bytes.push_back(8'($urandom));
        send_buffer(bytes, total);
    endtask

    initial
    begin : stimulus
        octet_q_t bytes;
        int       prof;
        int       target;
        rst_n                    = 1'b0;
        stream_bus.valid         = 1'b0;
        stream_bus.data_byte     = 8'd0;
        stream_bus.buffer_start  = 1'b0;
        stream_bus.buffer_length = 16'd0;
        send_idle_pct            = 6;
        recv_stall_pct           = 63;
        bytes_sent               = 0;
        buffers_sent             = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_byte(ID_RSN, 1'b0, 16'hffff);
        bytes = {ID_RSN};
        send_buffer(bytes, 16'd0);
        bytes = {ID_VENDOR, 8'h06, 8'h00, 8'h50, 8'hf2, 8'h01, 8'h01, 8'h00};
        send_buffer(bytes, 16'd8);
        bytes = {ID_RSN, 8'h0e, 8'h01, 8'h00, 8'h00, 8'h10, 8'h18, 8'h02,
                 8'h00, 8'h00, 8'hff, 8'hff, 8'h00};
        send_buffer(bytes, 16'd12);
        bytes = {ID_VENDOR, 8'h16, 8'h00, 8'h50};
        send_buffer(bytes, 16'h8000);
        bytes = {8'h01, 8'h00, 8'h7f, ID_RSN};
        send_buffer(bytes, 16'd3);

        for (prof = 0; prof < 3; prof++)
        begin
            send_idle_pct  = (prof == 0) ? 6 : (prof == 1) ? 63 : 0;
            recv_stall_pct = (prof == 0) ? 63 : (prof == 1) ? 6 : 0;
            target         = bytes_sent + 165;
            while (bytes_sent < target)
                send_random_buffer();
        end
        stream_bus.valid = 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Drove %0d bytes in %0d buffers under three stall profiles.",
                 bytes_sent, buffers_sent);
        $display("Compared %0d records, %0d mismatches.", records_checked, fail_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
